// File: src/fwss_pkg.sv
// ----------------------------------------------------------------------------
// fwss_pkg
// Shared types and codes of the four-way signal sequencer.
// ----------------------------------------------------------------------------
package fwss_pkg;

  localparam int KIND_W   = 3;
  localparam int MODE_W   = 2;
  localparam int DRAW_W   = 4;
  localparam int LAMP_W   = 3;
  localparam int IV_W     = 2;
  localparam int LEFT_W   = 8;
  localparam int IDLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_HEADS  = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SETMODE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;

  // modes
  localparam logic [MODE_W-1:0] MODE_SEQ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLASH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PHASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

  // intervals; in flash, IV_GREEN = ambers lit, IV_AMBER = dark
  localparam logic [IV_W-1:0] IV_GREEN    = 2'd0;
  localparam logic [IV_W-1:0] IV_AMBER    = 2'd1;
  localparam logic [IV_W-1:0] IV_REDAMBER = 2'd2;

  // lamp bits
  localparam logic [LAMP_W-1:0] LAMP_DARK  = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_RED   = 3'b100;
  localparam logic [LAMP_W-1:0] LAMP_AMBER = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b001;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_ORDER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_ORDER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_GREEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMBER        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED_AMBER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_MODE    = 3'd6;

  typedef struct packed {
    logic [7:0]        phase_order;
    logic [7:0]        seq_order;
    logic [IDLE_W-1:0] idle_timeout;
    logic [7:0]        seq_green;
    logic [3:0]        amber;
    logic [3:0]        red_amber;
    logic [MODE_W-1:0] init_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    phase_order:  8'd228,
    seq_order:    8'd228,
    idle_timeout: 16'd40,
    seq_green:    8'd5,
    amber:        4'd2,
    red_amber:    4'd2,
    init_mode:    MODE_SEQ
  };

  // sequencer state, slot kept apart since its width follows the head count
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IV_W-1:0]   interval;
    logic [LEFT_W-1:0] left;
    logic [IDLE_W-1:0] idle;
  } state_t;

  typedef logic [OUT_HEADS-1:0][LAMP_W-1:0] lamps_t;

endpackage

// File: src/fwss_if.sv
// ----------------------------------------------------------------------------
// fwss_if
// Valid/ready channels of the sequencer: command input, result, config write.
// ----------------------------------------------------------------------------
interface fwss_in_if import fwss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [MODE_W-1:0] new_mode;
  logic [DRAW_W-1:0] green_draw;

  modport source (output valid, kind, new_mode, green_draw, input ready);
  modport sink   (input valid, kind, new_mode, green_draw, output ready);
endinterface

interface fwss_out_if import fwss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LAMP_W-1:0] head1_lamps;
  logic [LAMP_W-1:0] head2_lamps;
  logic [LAMP_W-1:0] head3_lamps;
  logic [LAMP_W-1:0] head4_lamps;
  logic [MODE_W-1:0] running_mode;
  logic [1:0]        order_slot;
  logic              timeout_fired;

  modport source (output valid, head1_lamps, head2_lamps, head3_lamps, head4_lamps,
                  running_mode, order_slot, timeout_fired, input ready);
  modport sink   (input valid, head1_lamps, head2_lamps, head3_lamps, head4_lamps,
                  running_mode, order_slot, timeout_fired, output ready);
endinterface

interface fwss_cfg_if import fwss_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/fwss_cfg_regs.sv
// ----------------------------------------------------------------------------
// fwss_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fwss_cfg_regs import fwss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_PHASE_ORDER:  cfg_d.phase_order  = wr_data_i[7:0];
        REG_SEQ_ORDER:    cfg_d.seq_order    = wr_data_i[7:0];
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout = wr_data_i[IDLE_W-1:0];
        REG_SEQ_GREEN:    cfg_d.seq_green    = wr_data_i[7:0];
        REG_AMBER:        cfg_d.amber        = wr_data_i[3:0];
        REG_RED_AMBER:    cfg_d.red_amber    = wr_data_i[3:0];
        REG_INIT_MODE:    cfg_d.init_mode    = wr_data_i[MODE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/fwss_step.sv
// ----------------------------------------------------------------------------
// fwss_step
// Next-state logic for one tick or command.
// ----------------------------------------------------------------------------
module fwss_step import fwss_pkg::*; #(
  parameter int NUM_HEADS = 4,
  localparam int SlotW = (NUM_HEADS > 4) ? 3 : 2
) (
  input  cfg_t              cfg_i,
  input  state_t            st_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [MODE_W-1:0] new_mode_i,
  input  logic [DRAW_W-1:0] draw_i,
  output state_t            st_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              fired_o
);

  logic [IDLE_W-1:0] idle_inc;
  logic [DRAW_W-1:0] draw_clamped;
  logic [LEFT_W-1:0] draw_len, seq_len, amber_len, redamber_len, green_len;
  logic [SlotW-1:0]  slot_next;
  logic              do_start;
  logic [MODE_W-1:0] mode_sel;

  assign idle_inc = (st_i.idle == '1) ? st_i.idle : st_i.idle + 1'b1;

  always_comb begin
    if (draw_i < DRAW_W'(3))       draw_clamped = DRAW_W'(3);
    else if (draw_i > DRAW_W'(10)) draw_clamped = DRAW_W'(10);
    else                           draw_clamped = draw_i;
  end

  // zero lengths count as one second
  assign draw_len     = LEFT_W'(draw_clamped);
  assign seq_len      = (cfg_i.seq_green == '0) ? LEFT_W'(1) : cfg_i.seq_green;
  assign amber_len    = (cfg_i.amber == '0) ? LEFT_W'(1) : LEFT_W'(cfg_i.amber);
  assign redamber_len = (cfg_i.red_amber == '0) ? LEFT_W'(1) : LEFT_W'(cfg_i.red_amber);
  assign green_len    = (st_i.mode == MODE_PHASE) ? draw_len : seq_len;

  assign slot_next = (slot_i == SlotW'(NUM_HEADS - 1)) ? '0 : slot_i + 1'b1;

  always_comb begin
    st_o     = st_i;
    slot_o   = slot_i;
    fired_o  = 1'b0;
    do_start = 1'b0;
    mode_sel = MODE_SEQ;

    if (kind_i == KIND_TICK) begin
      st_o.idle = idle_inc;
      if (st_i.mode == MODE_PHASE && idle_inc >= cfg_i.idle_timeout) begin
        do_start  = 1'b1;
        mode_sel  = MODE_SEQ;
        st_o.idle = '0;
        fired_o   = 1'b1;
      end else if (st_i.mode == MODE_FLASH) begin
        st_o.interval = (st_i.interval == IV_GREEN) ? IV_AMBER : IV_GREEN;
        st_o.left     = LEFT_W'(1);
      end else if (st_i.mode != MODE_OFF) begin
        if (st_i.left > LEFT_W'(1)) begin
          st_o.left = st_i.left - 1'b1;
        end else if (st_i.interval == IV_GREEN) begin
          st_o.interval = IV_AMBER;
          st_o.left     = amber_len;
        end else if (st_i.interval == IV_AMBER) begin
          st_o.interval = IV_REDAMBER;
          st_o.left     = redamber_len;
        end else begin
          slot_o        = slot_next;
          st_o.interval = IV_GREEN;
          st_o.left     = green_len;
        end
      end
    end else if (kind_i <= KIND_CLOSE) begin
      st_o.idle = '0;
      if (kind_i == KIND_SETMODE) begin
        do_start = 1'b1;
        mode_sel = new_mode_i;
      end else if (kind_i == KIND_RESTART) begin
        do_start = 1'b1;
        mode_sel = cfg_i.init_mode;
      end else if (kind_i == KIND_CLOSE) begin
        do_start = 1'b1;
        mode_sel = MODE_OFF;
      end
    end

    if (do_start) begin
      st_o.mode     = mode_sel;
      slot_o        = '0;
      st_o.interval = IV_GREEN;
      if (mode_sel == MODE_SEQ)        st_o.left = seq_len;
      else if (mode_sel == MODE_PHASE) st_o.left = draw_len;
      else                             st_o.left = LEFT_W'(1);
    end
  end

endmodule

// File: src/fwss_lamps.sv
// ----------------------------------------------------------------------------
// fwss_lamps
// Lamp decode of the four heads from mode, interval and slot.
// ----------------------------------------------------------------------------
module fwss_lamps import fwss_pkg::*; #(
  parameter int NUM_HEADS = 4,
  localparam int SlotW = (NUM_HEADS > 4) ? 3 : 2
) (
  input  cfg_t              cfg_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [IV_W-1:0]   interval_i,
  input  logic [SlotW-1:0]  slot_i,
  output lamps_t            lamps_o
);

  logic [7:0]       order;
  logic [SlotW-1:0] slot_next;
  logic [1:0]       cur_head, nxt_head;
  lamps_t           raw;

  assign order     = (mode_i == MODE_PHASE) ? cfg_i.phase_order : cfg_i.seq_order;
  assign slot_next = (slot_i == SlotW'(NUM_HEADS - 1)) ? '0 : slot_i + 1'b1;
  // slot s reads order entry s mod 4
  assign cur_head  = order[{slot_i[1:0], 1'b0} +: 2];
  assign nxt_head  = order[{slot_next[1:0], 1'b0} +: 2];

  always_comb begin
    for (int h = 0; h < OUT_HEADS; h++) begin
      raw[h] = LAMP_DARK;
      unique case (mode_i)
        MODE_OFF:   raw[h] = LAMP_DARK;
        MODE_FLASH: raw[h] = (interval_i == IV_GREEN) ? LAMP_AMBER : LAMP_DARK;
        default: begin
          raw[h] = LAMP_RED;
          if (interval_i == IV_AMBER) begin
            if (cur_head == 2'(h)) raw[h] = LAMP_AMBER;
          end else if (interval_i == IV_REDAMBER) begin
            if (nxt_head == 2'(h)) raw[h] = LAMP_RED | LAMP_AMBER;
          end else begin
            if (cur_head == 2'(h)) raw[h] = LAMP_GREEN;
          end
        end
      endcase
      lamps_o[h] = (h < NUM_HEADS) ? raw[h] : LAMP_DARK;
    end
  end

endmodule

// File: src/four_way_signal_sequencer_top.sv
// ----------------------------------------------------------------------------
// four_way_signal_sequencer_top
// Four-head red/amber/green sequencer with sequence, phase, flash and off.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one word per one-second tick or command event (kind, new_mode,
//            green_draw). Each accepted word yields exactly one result word.
//   out_o  - lamp states of the four heads, running mode, order slot and the
//            idle-timeout flag, as they stand after that word.
//   cfg_i  - register writes (index, data); always ready, write only while
//            no word is in flight.
// Latency: a result shows on out_o the cycle after its word is accepted.
// Throughput: one word per cycle while results are taken. State update and lamp decode sit in one
//   combinational pass between the state registers and the result register.
// Stall: in_i.ready stays high while the result register is empty or being
//   emptied in the same cycle; a stalled result holds and blocks new words.
// Reset: config registers take their documented defaults, the block starts in
//   sequence mode at slot 0 in green, the idle count is cleared and no
//   result is pending. There is no clearing pass; words are taken at once.
// ----------------------------------------------------------------------------
module four_way_signal_sequencer_top import fwss_pkg::*; #(
  parameter int NUM_HEADS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fwss_in_if.sink      in_i,
  fwss_out_if.source   out_o,
  fwss_cfg_if.sink     cfg_i
);

  localparam int SlotW = (NUM_HEADS > 4) ? 3 : 2;

  cfg_t             cfg;
  state_t           st_q, st_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             fired;
  lamps_t           lamps;
  logic             accept;

  // result register
  logic              out_valid_q;
  lamps_t            lamps_q;
  logic [MODE_W-1:0] mode_q;
  logic [1:0]        oslot_q;
  logic              fired_q;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  fwss_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // next state for the word at the input
  fwss_step #(.NUM_HEADS(NUM_HEADS)) u_step (
    .cfg_i      (cfg),
    .st_i       (st_q),
    .slot_i     (slot_q),
    .kind_i     (in_i.kind),
    .new_mode_i (in_i.new_mode),
    .draw_i     (in_i.green_draw),
    .st_o       (st_d),
    .slot_o     (slot_d),
    .fired_o    (fired)
  );

  // lamps are decoded from the state the word leaves behind
  fwss_lamps #(.NUM_HEADS(NUM_HEADS)) u_lamps (
    .cfg_i      (cfg),
    .mode_i     (st_d.mode),
    .interval_i (st_d.interval),
    .slot_i     (slot_d),
    .lamps_o    (lamps)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= MODE_SEQ;
      st_q.interval <= IV_GREEN;
      st_q.left     <= CFG_RESET.seq_green;
      st_q.idle     <= '0;
      slot_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        st_q   <= st_d;
        slot_q <= slot_d;
      end
      if (accept)           out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lamps_q <= lamps;
      mode_q  <= st_d.mode;
      oslot_q <= (st_d.mode == MODE_SEQ || st_d.mode == MODE_PHASE) ? slot_d[1:0] : 2'd0;
      fired_q <= fired;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.head1_lamps   = lamps_q[0];
  assign out_o.head2_lamps   = lamps_q[1];
  assign out_o.head3_lamps   = lamps_q[2];
  assign out_o.head4_lamps   = lamps_q[3];
  assign out_o.running_mode  = mode_q;
  assign out_o.order_slot    = oslot_q;
  assign out_o.timeout_fired = fired_q;

endmodule

// File: src/fwss_checker.sv
// ----------------------------------------------------------------------------
// fwss_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fwss_checker import fwss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LAMP_W-1:0] head1_lamps,
  input logic [LAMP_W-1:0] head2_lamps,
  input logic [LAMP_W-1:0] head3_lamps,
  input logic [LAMP_W-1:0] head4_lamps,
  input logic [MODE_W-1:0] running_mode,
  input logic [1:0]        order_slot,
  input logic              timeout_fired
);

  logic [4*LAMP_W-1:0] all_lamps;
  assign all_lamps = {head4_lamps, head3_lamps, head2_lamps, head1_lamps};

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(all_lamps) && $stable(running_mode))
    else $error("result changed while stalled");

  // every accepted word gives a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && running_mode == MODE_OFF |-> all_lamps == '0)
    else $error("lamp lit in off mode");

  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && timeout_fired |-> running_mode == MODE_SEQ && order_slot == 2'd0)
    else $error("timeout did not restart sequence at slot 0");

  a_flash_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (running_mode == MODE_FLASH || running_mode == MODE_OFF)
      |-> order_slot == 2'd0)
    else $error("slot nonzero outside sequence and phase");

endmodule

bind four_way_signal_sequencer_top fwss_checker u_fwss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .head1_lamps   (out_o.head1_lamps),
  .head2_lamps   (out_o.head2_lamps),
  .head3_lamps   (out_o.head3_lamps),
  .head4_lamps   (out_o.head4_lamps),
  .running_mode  (out_o.running_mode),
  .order_slot    (out_o.order_slot),
  .timeout_fired (out_o.timeout_fired)
);
